// ===== rtl/core/point_to_octree_code_defines.svh =====
// Assertion macros used by the octree code sequencer.
`ifndef POINT_TO_OCTREE_CODE_DEFINES_SVH
`define POINT_TO_OCTREE_CODE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PTOC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define PTOC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ptoc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptoc_pkg;

   typedef struct packed {
      logic [15:0] x_frac;
      logic [15:0] y_frac;
      logic [15:0] z_frac;
      logic [15:0] cube_size;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } ptoc_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } ptoc_rsp_type;

   typedef enum logic [2:0] {
      PTOC_IDLE,
      PTOC_DEPTH,
      PTOC_CODE,
      PTOC_RED,
      PTOC_GREEN,
      PTOC_BLUE
   } ptoc_state_type;

   // Commands from the sequencer to the shift unit
   typedef struct packed {
      logic load;
      logic size_shift;
      logic bit_step;
   } ptoc_ctrl_type;

   // Status from the shift unit to the sequencer
   typedef struct packed {
      logic size_msb;
      logic code_bit;
   } ptoc_stat_type;

   localparam logic [1:0] PTOC_AXIS_LAST = 2'd2;
   localparam logic [2:0] PTOC_USED_FULL = 3'd7;
   localparam int         PTOC_BYTE_BITS = 8;

endpackage

`default_nettype wire

// ===== rtl/core/point_to_octree_code.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Point to octree code: takes one point, a cube size and a colour, and sends a
// byte stream: the depth k, then ceil(3k/8) code bytes (x, y, z bit per level,
// MSB first, last byte zero-padded), then red, green and blue, with last_byte
// set on blue. One byte per rsp_strobe cycle; the receiver cannot stall, so
// every strobed byte must be taken. busy stays high from the accept until the
// blue byte is on the output. The depth search shifts the size one bit per
// cycle and the shared shift unit moves one code bit per cycle.
module point_to_octree_code
   import ptoc_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int MAX_DEPTH  = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire ptoc_req_type req_item,
   output logic              rsp_strobe,
   output ptoc_rsp_type      rsp_item
);

   ptoc_ctrl_type ctrl;
   ptoc_stat_type stat;

   ptoc_shift_unit #(
      .COORD_BITS(COORD_BITS)
   ) u_shift (
      .clock   (clock),
      .req_item(req_item),
      .ctrl    (ctrl),
      .stat    (stat)
   );

   ptoc_sequencer #(
      .MAX_DEPTH(MAX_DEPTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .stat      (stat),
      .ctrl      (ctrl),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

// ===== rtl/core/ptoc_shift_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptoc_shift_unit
   import ptoc_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  wire logic          clock,
   input  wire ptoc_req_type  req_item,
   input  wire ptoc_ctrl_type ctrl,
   output ptoc_stat_type      stat
);

   logic [COORD_BITS-1:0] size_ff, size_in;
   logic [COORD_BITS-1:0] cx_ff, cx_in;
   logic [COORD_BITS-1:0] cy_ff, cy_in;
   logic [COORD_BITS-1:0] cz_ff, cz_in;
   logic [COORD_BITS-1:0] vx, vy, vz;

   always_comb begin
      vx = COORD_BITS'(req_item.x_frac);
      vy = COORD_BITS'(req_item.y_frac);
      vz = COORD_BITS'(req_item.z_frac);
      size_in = size_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      cz_in   = cz_ff;
      if (ctrl.load) begin
         size_in = COORD_BITS'(req_item.cube_size);
         // boundary points fall in the lower cell
         cx_in = (vx == '0) ? '0 : vx - 1'b1;
         cy_in = (vy == '0) ? '0 : vy - 1'b1;
         cz_in = (vz == '0) ? '0 : vz - 1'b1;
      end else begin
         if (ctrl.size_shift) begin
            size_in = size_ff << 1;
         end
         // rotate x -> z -> y -> x; x shifts as it wraps, so after three steps
         // every axis has moved down one level and zeros fill past precision
         if (ctrl.bit_step) begin
            cx_in = cy_ff;
            cy_in = cz_ff;
            cz_in = cx_ff << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
   end

   assign stat.size_msb = size_ff[COORD_BITS-1];
   assign stat.code_bit = cx_ff[COORD_BITS-1];

endmodule

`default_nettype wire

// ===== rtl/core/ptoc_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "point_to_octree_code_defines.svh"

module ptoc_sequencer
   import ptoc_pkg::*;
#(
   parameter int MAX_DEPTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire ptoc_req_type  req_item,
   input  wire ptoc_stat_type stat,
   output ptoc_ctrl_type      ctrl,
   output logic               busy,
   output logic               rsp_strobe,
   output ptoc_rsp_type       rsp_item
);

   localparam int LW = $clog2(MAX_DEPTH + 1);

   ptoc_state_type state_ff, state_in;
   logic [LW-1:0]  level_ff, level_in;
   logic [LW-1:0]  depth_ff, depth_in;
   logic [1:0]     axis_ff, axis_in;
   logic [7:0]     acc_ff, acc_in;
   logic [2:0]     used_ff, used_in;
   logic           rsp_valid_ff, rsp_valid_in;
   ptoc_rsp_type   rsp_ff, rsp_in;
   logic [7:0]     red_ff, red_in;
   logic [7:0]     green_ff, green_in;
   logic [7:0]     blue_ff, blue_in;
   logic [7:0]     next_acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PTOC_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      depth_ff <= depth_in;
      axis_ff  <= axis_in;
      acc_ff   <= acc_in;
      used_ff  <= used_in;
      rsp_ff   <= rsp_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      depth_in     = depth_ff;
      axis_in      = axis_ff;
      acc_in       = acc_ff;
      used_in      = used_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      ctrl         = '0;
      next_acc     = {acc_ff[6:0], stat.code_bit};
      case (state_ff)
         PTOC_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               red_in    = req_item.red;
               green_in  = req_item.green;
               blue_in   = req_item.blue;
               level_in  = '0;
               state_in  = PTOC_DEPTH;
            end
         end
         PTOC_DEPTH: begin
            // stop at the first set size bit, or saturate
            if (level_ff == LW'(MAX_DEPTH) || stat.size_msb) begin
               depth_in        = level_ff;
               rsp_valid_in    = 1'b1;
               rsp_in.out_byte = 8'(level_ff);
               level_in        = '0;
               axis_in         = '0;
               acc_in          = '0;
               used_in         = '0;
               state_in        = PTOC_CODE;
            end else begin
               ctrl.size_shift = 1'b1;
               level_in        = LW'(level_ff + 1'b1);
            end
         end
         PTOC_CODE: begin
            if (axis_ff == '0 && level_ff == depth_ff) begin
               // flush a partial byte, zero-padded at the bottom
               if (used_ff != '0) begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.out_byte = acc_ff << (4'(PTOC_BYTE_BITS) - {1'b0, used_ff});
               end
               state_in = PTOC_RED;
            end else begin
               ctrl.bit_step = 1'b1;
               if (used_ff == PTOC_USED_FULL) begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.out_byte = next_acc;
                  acc_in          = '0;
                  used_in         = '0;
               end else begin
                  acc_in  = next_acc;
                  used_in = used_ff + 3'd1;
               end
               if (axis_ff == PTOC_AXIS_LAST) begin
                  axis_in  = '0;
                  level_in = LW'(level_ff + 1'b1);
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end
         end
         PTOC_RED: begin
            rsp_valid_in    = 1'b1;
            rsp_in.out_byte = red_ff;
            state_in        = PTOC_GREEN;
         end
         PTOC_GREEN: begin
            rsp_valid_in    = 1'b1;
            rsp_in.out_byte = green_ff;
            state_in        = PTOC_BLUE;
         end
         PTOC_BLUE: begin
            rsp_valid_in     = 1'b1;
            rsp_in.out_byte  = blue_ff;
            rsp_in.last_byte = 1'b1;
            state_in         = PTOC_IDLE;
         end
         default: begin
            state_in = PTOC_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != PTOC_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   `PTOC_ASSERT_NEXT(a_start_enters_depth, clock, reset, start && !busy, state_ff == PTOC_DEPTH, "transfer accepted but depth search not started")
   `PTOC_ASSERT_NOW(a_last_ends_item, clock, reset, rsp_valid_ff && rsp_ff.last_byte, state_ff == PTOC_IDLE, "last byte sent while item still in progress")
   `PTOC_ASSERT_NOW(a_depth_bound, clock, reset, state_ff == PTOC_DEPTH, level_ff <= LW'(MAX_DEPTH), "depth search ran past its limit")
   `PTOC_ASSERT_NOW(a_code_level_bound, clock, reset, state_ff == PTOC_CODE, level_ff <= depth_ff && depth_ff <= LW'(MAX_DEPTH), "code level past chosen depth")

endmodule

`default_nettype wire

// ===== tb/point_to_octree_code_tb.sv =====
`timescale 1ns / 1ps

module point_to_octree_code_tb;
   import ptoc_pkg::*;

   localparam int COORD_BITS     = 16;
   localparam int MAX_DEPTH      = 16;
   localparam int DIR_ROWS       = 18;
   localparam int RAND_POINTS    = 112;
   localparam int CALM_TAIL      = 25;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      ptoc_req_type req;
      logic [3:0]   n_typed;  // 0: take the expected bytes from the code predictor
      logic [79:0]  typed;    // right-aligned, first byte in the highest used slot
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   ptoc_req_type req_item;
   logic         rsp_strobe;
   ptoc_rsp_type rsp_item;

   ptoc_rsp_type   code_bytes_q [$];
   stim_row_type   stim_tab [DIR_ROWS];
   logic [MAX_DEPTH:0] depths_seen;
   int err_count;
   int bytes_checked;
   int points_sent;
   int quiet_cycles;

   point_to_octree_code #(
      .COORD_BITS(COORD_BITS),
      .MAX_DEPTH (MAX_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic stim_row_type mk_row(input logic [15:0] x, input logic [15:0] y,
                                           input logic [15:0] z, input logic [15:0] size,
                                           input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input logic [3:0] n,
                                           input logic [79:0] typed);
      stim_row_type row;
      row.req.x_frac    = x;
      row.req.y_frac    = y;
      row.req.z_frac    = z;
      row.req.cube_size = size;
      row.req.red       = r;
      row.req.green     = g;
      row.req.blue      = b;
      row.n_typed       = n;
      row.typed         = typed;
      return row;
   endfunction

   function automatic void push_byte(input logic [7:0] b, input logic last);
      ptoc_rsp_type r;
      r.out_byte  = b;
      r.last_byte = last;
      code_bytes_q.push_back(r);
   endfunction

   // Depth byte, interleaved x/y/z level bits packed MSB first, then the colour.
   function automatic void predict_code_bytes(input ptoc_req_type it);
      logic [15:0] pos [0:2];
      logic [7:0]  acc;
      logic        lvl_bit;
      int          depth, k, lvl, ax, used;
      pos[0] = (it.x_frac == 16'd0) ? 16'd0 : it.x_frac - 16'd1;
      pos[1] = (it.y_frac == 16'd0) ? 16'd0 : it.y_frac - 16'd1;
      pos[2] = (it.z_frac == 16'd0) ? 16'd0 : it.z_frac - 16'd1;
      depth = MAX_DEPTH;
      for (k = 0; k < MAX_DEPTH && depth == MAX_DEPTH; k++) begin
         if (it.cube_size != 16'd0 &&
             (k >= COORD_BITS - 1 || 32'(it.cube_size) >= (32'd1 << (COORD_BITS - 1 - k))))
            depth = k;
      end
      push_byte(8'(depth), 1'b0);
      acc  = 8'd0;
      used = 0;
      for (lvl = 0; lvl < depth; lvl++) begin
         for (ax = 0; ax < 3; ax++) begin
            lvl_bit = (lvl < COORD_BITS) ? pos[ax][COORD_BITS - 1 - lvl] : 1'b0;
            acc = {acc[6:0], lvl_bit};
            used++;
            if (used == PTOC_BYTE_BITS) begin
               push_byte(acc, 1'b0);
               acc  = 8'd0;
               used = 0;
            end
         end
      end
      // zero-pad the partial code byte, also with 7 bits used
      if (used > 0)
         push_byte(acc << (PTOC_BYTE_BITS - used), 1'b0);
      push_byte(it.red, 1'b0);
      push_byte(it.green, 1'b0);
      push_byte(it.blue, 1'b1);
   endfunction

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h0001;
         2: return 16'hFFFF;
         3: return 16'h8000 + 16'($urandom_range(0, 1));
         default: return 16'($urandom);
      endcase
   endfunction

   // Aim at every depth evenly; now and then a size with no aim at all.
   function automatic ptoc_req_type random_point();
      ptoc_req_type it;
      int           k;
      logic [15:0]  lo;
      k = $urandom_range(0, MAX_DEPTH);
      it.x_frac = pick_coord();
      it.y_frac = pick_coord();
      it.z_frac = pick_coord();
      if ($urandom_range(0, 9) == 0)
         it.cube_size = 16'($urandom);
      else if (k == MAX_DEPTH)
         it.cube_size = 16'd0;
      else begin
         lo = 16'(32'd1 << (COORD_BITS - 1 - k));
         it.cube_size = lo + 16'($urandom % lo);
      end
      it.red   = 8'($urandom);
      it.green = 8'($urandom);
      it.blue  = 8'($urandom);
      return it;
   endfunction

   function automatic void flag_error(input string msg);
      err_count++;
      if (err_count <= REPORT_LIMIT)
         $display("%s", msg);
   endfunction

   // Hold start and the item until the transfer, then queue its expected bytes.
   task automatic send_point(input ptoc_req_type it, input logic [3:0] n_typed,
                             input logic [79:0] typed);
      int base;
      int i;
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      base = code_bytes_q.size();
      if (n_typed == 4'd0)
         predict_code_bytes(it);
      else begin
         for (i = 0; i < n_typed; i++)
            push_byte(typed[8 * (n_typed - 1 - i) +: 8], i == n_typed - 1);
      end
      depths_seen[code_bytes_q[base].out_byte] = 1'b1;
      points_sent++;
   endtask

   task automatic sender_gap(input int n);
      start    <= 1'b0;
      req_item <= ptoc_req_type'(88'({$urandom, $urandom, $urandom}));
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_all_bytes();
      start <= 1'b0;
      @(posedge clock);
      while (code_bytes_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      ptoc_rsp_type want;
      if (reset)
         quiet_cycles <= 0;
      else begin
         if (rsp_strobe || (start && !busy))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_strobe) begin
            if (code_bytes_q.size() == 0)
               flag_error($sformatf("unexpected byte %h last %b",
                                    rsp_item.out_byte, rsp_item.last_byte));
            else begin
               want = code_bytes_q.pop_front();
               bytes_checked++;
               if (rsp_item.out_byte !== want.out_byte)
                  flag_error($sformatf("out_byte mismatch: expected %h, got %h",
                                       want.out_byte, rsp_item.out_byte));
               if (rsp_item.last_byte !== want.last_byte)
                  flag_error($sformatf("last_byte mismatch on %h: expected %b, got %b",
                                       want.out_byte, want.last_byte, rsp_item.last_byte));
            end
         end
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int i;
      int dir_bytes;
      err_count     = 0;
      bytes_checked = 0;
      points_sent   = 0;
      quiet_cycles  = 0;
      depths_seen   = '0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_item <= '0;

      // after reset, extremes, boundary points and partial code bytes of 2, 3, 5, 6 and 7 bits
      stim_tab[0]  = mk_row(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 8'h00, 8'h00, 8'h00,
                            4'd4, 80'h00000000);
      stim_tab[1]  = mk_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 8'hFF, 8'hFF, 8'hFF,
                            4'd4, 80'h00FFFFFF);
      stim_tab[2]  = mk_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h12, 8'h34, 8'h56,
                            4'd10, 80'h10000000000000123456);
      stim_tab[3]  = mk_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 8'hA5, 8'h5A, 8'hC3,
                            4'd10, 80'h10FFFFFFFFFFF8A55AC3);
      stim_tab[4]  = mk_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h4000, 8'h01, 8'h02, 8'h03,
                            4'd5, 80'h01E0010203);
      stim_tab[5]  = mk_row(16'h8000, 16'h8000, 16'h8000, 16'h4000, 8'h80, 8'h40, 8'h20,
                            4'd5, 80'h0100804020);
      stim_tab[6]  = mk_row(16'h8001, 16'h8001, 16'h8001, 16'h4000, 8'h11, 8'h22, 8'h33,
                            4'd0, '0);
      stim_tab[7]  = mk_row(16'hFFFF, 16'h0000, 16'h0000, 16'h7FFF, 8'h44, 8'h55, 8'h66,
                            4'd0, '0);
      stim_tab[8]  = mk_row(16'h0000, 16'hFFFF, 16'h0000, 16'h2000, 8'h77, 8'h88, 8'h99,
                            4'd0, '0);
      stim_tab[9]  = mk_row(16'h0000, 16'h0000, 16'hFFFF, 16'h0400, 8'hAA, 8'hBB, 8'hCC,
                            4'd0, '0);
      stim_tab[10] = mk_row(16'h1234, 16'h5678, 16'h9ABC, 16'h0004, 8'hDD, 8'hEE, 8'h0F,
                            4'd0, '0);
      stim_tab[11] = mk_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 8'h5A, 8'hA5, 8'h3C,
                            4'd0, '0);
      stim_tab[12] = mk_row(16'h0001, 16'h0001, 16'h0001, 16'h0000, 8'hC3, 8'h96, 8'h69,
                            4'd0, '0);
      stim_tab[13] = mk_row(16'h0002, 16'h0002, 16'h0002, 16'h0000, 8'h01, 8'h80, 8'h7F,
                            4'd0, '0);
      stim_tab[14] = mk_row(16'hAAAA, 16'h5555, 16'hFFFF, 16'h0080, 8'hFE, 8'h10, 8'hEF,
                            4'd0, '0);
      stim_tab[15] = mk_row(16'h5555, 16'hAAAA, 16'h0000, 16'h0003, 8'h08, 8'hF7, 8'h40,
                            4'd0, '0);
      stim_tab[16] = mk_row(16'h8000, 16'h7FFF, 16'h8001, 16'h0000, 8'h02, 8'hFD, 8'hBF,
                            4'd0, '0);
      stim_tab[17] = mk_row(16'hDEAD, 16'hBEEF, 16'hCAFE, 16'hFFFF, 8'h00, 8'hFF, 8'h00,
                            4'd4, 80'h0000FF00);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++)
         send_point(stim_tab[i].req, stim_tab[i].n_typed, stim_tab[i].typed);
      dir_bytes = points_sent;

      for (i = 0; i < RAND_POINTS; i++) begin
         if (i == 40 || i == 90)
            wait_all_bytes();
         else if (i < RAND_POINTS - CALM_TAIL && $urandom_range(0, 3) == 0)
            sender_gap($urandom_range(1, 8));
         send_point(random_point(), 4'd0, '0);
      end

      wait_all_bytes();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (code_bytes_q.size() != 0)
         flag_error($sformatf("%0d expected bytes never came", code_bytes_q.size()));

      $display("Sent %0d points (%0d from the table), checked %0d bytes, %0d errors",
               points_sent, dir_bytes, bytes_checked, err_count);
      $display("Code depths reached (bit k set for depth k): %b", depths_seen);
      if (err_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
